// ----- src/emrg_pkg.sv -----
// Package of the maze row generator: sizes, item structs, cell command and
// tap structs, cell operation codes and the free label search.
// No dependencies.
package emrg_pkg;

    localparam int MAX_COLUMNS = 16;
    localparam int COL_W       = $clog2(MAX_COLUMNS);
    localparam int WIDTH_W     = $clog2(MAX_COLUMNS + 1);
    localparam int EAST_W      = MAX_COLUMNS - 1;

    typedef struct packed {
        logic [EAST_W-1:0]      merge_bits;
        logic [MAX_COLUMNS-1:0] down_bits;
        logic                   last_row;
    } row_item_t;

    typedef struct packed {
        logic [EAST_W-1:0]      east_open;
        logic [MAX_COLUMNS-1:0] south_open;
        logic                   maze_done;
    } res_item_t;

    localparam logic [2:0] OP_HOLD   = 3'd0;
    localparam logic [2:0] OP_RESET  = 3'd1;
    localparam logic [2:0] OP_LOAD   = 3'd2;
    localparam logic [2:0] OP_MERGE  = 3'd3;
    localparam logic [2:0] OP_SEED_R = 3'd4;
    localparam logic [2:0] OP_FORCE  = 3'd5;
    localparam logic [2:0] OP_SEED_L = 3'd6;
    localparam logic [2:0] OP_FRESH  = 3'd7;

    typedef struct packed {
        logic [2:0]       op;
        logic             last;
        logic             join_en;
        logic [COL_W-1:0] from_label;
        logic [COL_W-1:0] to_label;
        logic             hit;
        logic [COL_W-1:0] fresh_label;
    } cell_cmd_t;

    typedef struct packed {
        logic                   join_en;
        logic [COL_W-1:0]       label;
        logic [COL_W-1:0]       right_label;
        logic                   closed;
        logic [MAX_COLUMNS-1:0] used_mask;
    } cell_tap_t;

    function automatic logic [COL_W-1:0] first_free(input logic [MAX_COLUMNS-1:0] used);
        logic [COL_W-1:0] r;
        r = COL_W'(MAX_COLUMNS - 1);
        for (int i = MAX_COLUMNS - 2; i >= 0; i--)
        begin
            if (!used[i])
            begin
                r = COL_W'(i);
            end
        end
        return r;
    endfunction

endpackage

// ----- src/emrg_cell.sv -----
// One column cell of the maze row chain: set label, passage, wall and token.
// Depends on emrg_pkg; in sweeps the token moves one cell per cycle.
module emrg_cell import emrg_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic [COL_W-1:0] col_idx,
    input  logic             in_use,
    input  logic             is_last,
    input  logic             merge_bit,
    input  logic             down_bit,
    input  cell_cmd_t        cmd,
    input  logic             tok_from_left,
    input  logic             tok_from_right,
    input  logic [COL_W-1:0] right_label,
    output logic [COL_W-1:0] label,
    output logic             tok,
    output logic             east,
    output logic             south,
    output logic             match,
    output cell_tap_t        tap
);

    logic [COL_W-1:0] label_reg, label_next;
    logic             open_reg, open_next;
    logic             east_reg, east_next;
    logic             merge_reg, merge_next;
    logic             tok_reg, tok_next;
    logic             join_req;

    assign join_req = tok_reg && (label_reg != right_label) && (cmd.last || merge_reg);

    always_comb
    begin
        label_next = label_reg;
        open_next  = open_reg;
        east_next  = east_reg;
        merge_next = merge_reg;
        tok_next   = 1'b0;
        case (cmd.op)
            OP_RESET:
            begin
                label_next = col_idx;
            end
            OP_LOAD:
            begin
                open_next  = down_bit && in_use;
                east_next  = 1'b0;
                merge_next = merge_bit;
                tok_next   = (col_idx == '0);
            end
            OP_MERGE:
            begin
                tok_next = tok_from_left;
                if (join_req)
                begin
                    east_next = 1'b1;
                end
                if (cmd.join_en && in_use && (label_reg == cmd.from_label))
                begin
                    label_next = cmd.to_label;
                end
            end
            OP_SEED_R:
            begin
                tok_next = is_last;
            end
            OP_FORCE:
            begin
                tok_next = tok_from_right;
                if (tok_reg && !cmd.hit)
                begin
                    open_next = 1'b1;
                end
            end
            OP_SEED_L:
            begin
                tok_next = (col_idx == '0);
            end
            OP_FRESH:
            begin
                tok_next = tok_from_left;
                if (tok_reg && !open_reg)
                begin
                    label_next = cmd.fresh_label;
                end
            end
            default:
            begin
                tok_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_reg <= 1'b0;
        end
        else
        begin
            tok_reg <= tok_next;
        end
    end

    always_ff @(posedge clk)
    begin
        label_reg <= label_next;
        open_reg  <= open_next;
        east_reg  <= east_next;
        merge_reg <= merge_next;
    end

    assign label = label_reg;
    assign tok   = tok_reg;
    assign east  = east_reg;
    assign south = open_reg;
    assign match = open_reg && in_use && (label_reg == cmd.from_label);

    always_comb
    begin
        tap.join_en     = join_req;
        tap.label       = tok_reg ? label_reg : '0;
        tap.right_label = tok_reg ? right_label : '0;
        tap.closed      = tok_reg && !open_reg;
        tap.used_mask   = (open_reg && in_use) ? (MAX_COLUMNS'(1) << label_reg) : '0;
    end

endmodule

// ----- src/eller_maze_row_generator.sv -----
// Top level of the maze row generator: sequencer, width register, result
// register and the chain of emrg_cell columns. Depends on emrg_pkg.
//
// Channel  Direction  Handshake            Payload
// row      to block   row_valid/row_stall  row_item_t (merge, down, last)
// res      from block res_valid/res_stall  res_item_t (east, south, done)
// cfg      to block   cfg_valid/cfg_ready  cfg_data (maze_width)
//
// A last row runs only the join sweep and then goes straight to S_FINISH.
// Other rows sweep the token three times: joins left to right, forced
// passages right to left, fresh labels left to right, one cell per cycle.
// After reset, the S_INIT state loads the column labels before the first item.
// A stalled result waits in its register while the next row is accepted.
module eller_maze_row_generator import emrg_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               row_valid,
    output logic               row_stall,
    input  row_item_t          row_item,
    output logic               res_valid,
    input  logic               res_stall,
    output res_item_t          res_item,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [WIDTH_W-1:0] cfg_data
);

    localparam logic [2:0] S_INIT   = 3'd0;
    localparam logic [2:0] S_IDLE   = 3'd1;
    localparam logic [2:0] S_MERGE  = 3'd2;
    localparam logic [2:0] S_FSEED  = 3'd3;
    localparam logic [2:0] S_FORCE  = 3'd4;
    localparam logic [2:0] S_USED   = 3'd5;
    localparam logic [2:0] S_FRESH  = 3'd6;
    localparam logic [2:0] S_FINISH = 3'd7;

    logic [2:0]             state_reg, state_next;
    logic [WIDTH_W-1:0]     width_reg, width_next;
    logic [COL_W-1:0]       cnt_reg, cnt_next;
    logic                   last_reg, last_next;
    logic [MAX_COLUMNS-1:0] used_reg, used_next;
    logic                   res_valid_reg, res_valid_next;
    res_item_t              res_reg, res_next;

    logic [WIDTH_W-1:0]     w_eff;
    logic [MAX_COLUMNS-1:0] in_use_vec, is_last_vec, tok_vec, east_vec, south_vec, match_vec;
    logic [COL_W-1:0]       label_vec [MAX_COLUMNS];
    cell_tap_t              tap_vec [MAX_COLUMNS];
    cell_tap_t              tap_all;
    cell_cmd_t              cmd;
    logic                   merge_end, sweep_end;

    always_comb
    begin
        if (width_reg < WIDTH_W'(2))
        begin
            w_eff = WIDTH_W'(2);
        end
        else if (width_reg > WIDTH_W'(MAX_COLUMNS))
        begin
            w_eff = WIDTH_W'(MAX_COLUMNS);
        end
        else
        begin
            w_eff = width_reg;
        end
    end

    genvar gi;
    generate
        for (gi = 0; gi < MAX_COLUMNS; gi++)
        begin : g_cell
            logic             tl, tr, mb;
            logic [COL_W-1:0] rl;
            assign in_use_vec[gi]  = WIDTH_W'(gi) < w_eff;
            assign is_last_vec[gi] = WIDTH_W'(gi) == (w_eff - WIDTH_W'(1));
            if (gi == 0)
            begin : g_left_end
                assign tl = 1'b0;
            end
            else
            begin : g_left
                assign tl = tok_vec[gi-1];
            end
            if (gi == MAX_COLUMNS - 1)
            begin : g_right_end
                assign tr = 1'b0;
                assign rl = '0;
                assign mb = 1'b0;
            end
            else
            begin : g_right
                assign tr = tok_vec[gi+1];
                assign rl = label_vec[gi+1];
                assign mb = row_item.merge_bits[gi];
            end
            emrg_cell u_cell (
                .clk            (clk),
                .rst_n          (rst_n),
                .col_idx        (COL_W'(gi)),
                .in_use         (in_use_vec[gi]),
                .is_last        (is_last_vec[gi]),
                .merge_bit      (mb),
                .down_bit       (row_item.down_bits[gi]),
                .cmd            (cmd),
                .tok_from_left  (tl),
                .tok_from_right (tr),
                .right_label    (rl),
                .label          (label_vec[gi]),
                .tok            (tok_vec[gi]),
                .east           (east_vec[gi]),
                .south          (south_vec[gi]),
                .match          (match_vec[gi]),
                .tap            (tap_vec[gi])
            );
        end
    endgenerate

    always_comb
    begin
        tap_all = '0;
        for (int i = 0; i < MAX_COLUMNS; i++)
        begin
            tap_all = tap_all | tap_vec[i];
        end
    end

    assign merge_end = {1'b0, cnt_reg} == (w_eff - WIDTH_W'(2));
    assign sweep_end = {1'b0, cnt_reg} == (w_eff - WIDTH_W'(1));
    assign row_stall = (state_reg != S_IDLE) || cfg_valid;
    assign cfg_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next     = state_reg;
        width_next     = width_reg;
        cnt_next       = cnt_reg;
        last_next      = last_reg;
        used_next      = used_reg;
        res_valid_next = res_valid_reg && res_stall;
        res_next       = res_reg;
        cmd.op          = OP_HOLD;
        cmd.last        = last_reg;
        cmd.join_en     = 1'b0;
        cmd.from_label  = '0;
        cmd.to_label    = tap_all.label;
        cmd.hit         = |match_vec;
        cmd.fresh_label = first_free(used_reg);
        case (state_reg)
            S_INIT:
            begin
                cmd.op     = OP_RESET;
                state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (cfg_valid)
                begin
                    cmd.op     = OP_RESET;
                    width_next = cfg_data;
                end
                else if (row_valid)
                begin
                    cmd.op     = OP_LOAD;
                    last_next  = row_item.last_row;
                    cnt_next   = '0;
                    state_next = S_MERGE;
                end
            end
            S_MERGE:
            begin
                cmd.op         = OP_MERGE;
                cmd.join_en    = tap_all.join_en;
                cmd.from_label = tap_all.right_label;
                cnt_next       = cnt_reg + COL_W'(1);
                if (merge_end)
                begin
                    state_next = last_reg ? S_FINISH : S_FSEED;
                end
            end
            S_FSEED:
            begin
                cmd.op     = OP_SEED_R;
                cnt_next   = '0;
                state_next = S_FORCE;
            end
            S_FORCE:
            begin
                cmd.op         = OP_FORCE;
                cmd.from_label = tap_all.label;
                cnt_next       = cnt_reg + COL_W'(1);
                if (sweep_end)
                begin
                    state_next = S_USED;
                end
            end
            S_USED:
            begin
                cmd.op     = OP_SEED_L;
                used_next  = tap_all.used_mask;
                cnt_next   = '0;
                state_next = S_FRESH;
            end
            S_FRESH:
            begin
                cmd.op   = OP_FRESH;
                cnt_next = cnt_reg + COL_W'(1);
                if (tap_all.closed)
                begin
                    used_next = used_reg | (MAX_COLUMNS'(1) << cmd.fresh_label);
                end
                if (sweep_end)
                begin
                    state_next = S_FINISH;
                end
            end
            S_FINISH:
            begin
                if (!res_valid_reg || !res_stall)
                begin
                    res_valid_next      = 1'b1;
                    res_next.east_open  = east_vec[EAST_W-1:0];
                    res_next.south_open = last_reg ? '0 : south_vec;
                    res_next.maze_done  = last_reg;
                    cmd.op              = last_reg ? OP_RESET : OP_HOLD;
                    state_next          = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_INIT;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_INIT;
            width_reg     <= WIDTH_W'(MAX_COLUMNS);
            cnt_reg       <= '0;
            last_reg      <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            width_reg     <= width_next;
            cnt_reg       <= cnt_next;
            last_reg      <= last_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        used_reg <= used_next;
        res_reg  <= res_next;
    end

    assign res_valid = res_valid_reg;
    assign res_item  = res_reg;

`ifndef SYNTHESIS
    a_token_single: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(tok_vec))
        else $error("more than one cell holds the token");

    a_token_in_sweep: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_MERGE || state_reg == S_FORCE || state_reg == S_FRESH)
        |-> $onehot(tok_vec))
        else $error("no cell holds the token during a sweep");

    a_done_no_south: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && res_reg.maze_done) |-> (res_reg.south_open == '0))
        else $error("last row result opens a passage downward");
`endif

endmodule
